@@ rtl/lks_pkg.sv @@
`default_nettype none

package lks_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned CFG_W = 5;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_TOUCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/lru_key_store_top.sv @@
`default_nettype none

// Channel   Direction  Handshake             Word
// in        input      in_valid_i/in_stall_o  in_item_t: operation, key
// out       output     out_valid_o/out_stall_i out_item_t: hit, evicted, evicted_key, occupancy
// cfg       input      cfg_valid_i/cfg_ready_o max_entries, 5 bits
//
// A clear empties the set and goes straight to its result. A lookup or touch walks the
// stored keys through the single read port of the key memory, one slot per cycle, then a
// touch shifts the newer keys down one slot per cycle and appends. One word is worked on
// at a time.
// Reset empties the set and sets capacity to min(16, CAPACITY); key memory needs no clearing.
// A result waits in an output register, so the next word is taken while out is stalled.

module lru_key_store_top
  import lks_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [KEY_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [KEY_W-1:0] mem_rdata;
  logic             res_push;
  logic             res_ready;
  out_item_t        res_data;

  assign cfg_ready_o = 1'b1;

  lks_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_ready_i (res_ready),
    .res_push_o  (res_push),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  lks_mem #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W),
    .DW    (KEY_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lks_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .data_i      (res_data),
    .ready_o     (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/lks_mem.sv @@
`default_nettype none

module lks_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/lks_out.sv @@
`default_nettype none

module lks_out
  import lks_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  out_item_t      data_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q;

  // The holding register can take a new word when empty or when its word leaves now.
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i && ready_o) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/lks_ctrl.sv @@
`default_nettype none

module lks_ctrl
  import lks_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  input  wire logic             res_ready_i,
  output logic                  res_push_o,
  output out_item_t             res_data_o,
  output logic                  mem_we_o,
  output logic      [IDX_W-1:0] mem_waddr_o,
  output logic      [KEY_W-1:0] mem_wdata_o,
  output logic      [IDX_W-1:0] mem_raddr_o,
  input  wire logic [KEY_W-1:0] mem_rdata_i
);

  localparam int unsigned EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_APPEND,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] max_q, max_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0] wa_q, wa_d;
  logic             wv_q, wv_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [KEY_W-1:0] slot0_q, slot0_d;
  logic             hit_q, hit_d;
  logic             evict_q, evict_d;
  logic [KEY_W-1:0] evk_q, evk_d;

  logic [EXT_W-1:0] cap_req, cap_max, cap_eff, count_ext;
  logic [CNT_W-1:0] rd_dec, cmp_next;
  logic             full, found, missed;

  always_comb begin
    cap_req   = EXT_W'(max_q);
    cap_max   = EXT_W'(CAPACITY);
    count_ext = EXT_W'(count_q);
    if (cap_req == '0) begin
      cap_eff = EXT_W'(1);
    end else if (cap_req > cap_max) begin
      cap_eff = cap_max;
    end else begin
      cap_eff = cap_req;
    end
    full     = (count_ext >= cap_eff);
    rd_dec   = rd_q - CNT_W'(1);
    cmp_next = cmp_idx_q + CNT_W'(1);
    found    = cmp_v_q && (mem_rdata_i == key_q);
    missed   = (count_q == '0) || (cmp_v_q && (cmp_next == count_q));
  end

  always_comb begin
    state_d   = state_q;
    max_d     = max_q;
    count_d   = count_q;
    rd_d      = rd_q;
    cmp_idx_d = cmp_idx_q;
    cmp_v_d   = 1'b0;
    wa_d      = wa_q;
    wv_d      = 1'b0;
    op_d      = op_q;
    key_d     = key_q;
    slot0_d   = slot0_q;
    hit_d     = hit_q;
    evict_d   = evict_q;
    evk_d     = evk_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = wa_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = rd_q[IDX_W-1:0];
    res_push_o  = 1'b0;

    if (cfg_valid_i) begin
      max_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.operation;
          key_d   = in_data_i.key;
          hit_d   = 1'b0;
          evict_d = 1'b0;
          evk_d   = '0;
          rd_d    = '0;
          if (in_data_i.operation == OP_CLEAR) begin
            count_d = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end

      // One slot is read per cycle; the word read last cycle is compared now.
      ST_SEARCH: begin
        if (cmp_v_q && (cmp_idx_q == '0)) begin
          slot0_d = mem_rdata_i;
        end
        if (found || missed) begin
          hit_d = found;
          if (op_q != OP_TOUCH) begin
            state_d = ST_DONE;
          end else if (found) begin
            rd_d    = cmp_next;
            state_d = ST_SHIFT;
          end else if (full) begin
            // Eviction of the oldest slot; slot zero was read first in the walk.
            evict_d = 1'b1;
            evk_d   = (cmp_idx_q == '0) ? mem_rdata_i : slot0_q;
            rd_d    = CNT_W'(1);
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_APPEND;
          end
        end else if (rd_q < count_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_q;
          rd_d      = rd_q + CNT_W'(1);
        end
      end

      // Each newer key moves one slot toward the oldest end, one slot per cycle.
      ST_SHIFT: begin
        mem_we_o = wv_q;
        if (rd_q < count_q) begin
          wv_d = 1'b1;
          wa_d = rd_dec[IDX_W-1:0];
          rd_d = rd_q + CNT_W'(1);
        end else if (!wv_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_APPEND;
        end
      end

      ST_APPEND: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = count_q[IDX_W-1:0];
        mem_wdata_o = key_q;
        count_d     = count_q + CNT_W'(1);
        state_d     = ST_DONE;
      end

      ST_DONE: begin
        res_push_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      max_q   <= MAX_ENTRIES_RESET;
      count_q <= '0;
      cmp_v_q <= 1'b0;
      wv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      max_q   <= max_d;
      count_q <= count_d;
      cmp_v_q <= cmp_v_d;
      wv_q    <= wv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    cmp_idx_q <= cmp_idx_d;
    wa_q      <= wa_d;
    op_q      <= op_d;
    key_q     <= key_d;
    slot0_q   <= slot0_d;
    hit_q     <= hit_d;
    evict_q   <= evict_d;
    evk_q     <= evk_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    res_data_o.hit         = hit_q;
    res_data_o.evicted     = evict_q;
    res_data_o.evicted_key = evk_q;
    res_data_o.occupancy   = count_ext[OCC_W-1:0];
  end

endmodule

`default_nettype wire
